// ----- rtl/s2l_pkg.sv -----
`default_nettype none
// ============================================================================
// s2l_pkg: shared types, constants and tables for the sRGB to CIELAB converter
// Holds the Q30 formats, the divide-by-constant factors and the gamma table.
// ============================================================================
package s2l_pkg;

    localparam int FRAC_BITS = 8;
    localparam int QB        = 30;
    localparam int LW        = QB + 1;          // width of a Q30 value up to 2.0
    localparam int XW        = 47;              // width of a scaled matrix sum
    localparam int CB_BITS   = LW;              // cube root result bits
    localparam int OW        = 42;              // signed L, a, b before rounding
    localparam int SH        = QB - FRAC_BITS;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Front of back end (8) + cube root (2 per bit) + scale and round (2).
    localparam int BACK_STAGES = 8 + 2 * CB_BITS + 2;

    localparam logic [LW-1:0] LAB_OFFSET = LW'((64'd16 << QB) / 116);
    localparam logic [LW-1:0] LAB_TH     = LW'((64'd8856 << QB) / 1000000);

    localparam int L_MAX_RAW = 100 << FRAC_BITS;
    localparam int L_MAX     = (L_MAX_RAW > 32767) ? 32767 : L_MAX_RAW;

    // Matrix rows for X (pre-scaled by 10), Y and Z (pre-scaled by 10).
    localparam logic [16:0] MAT [3][3] = '{
        '{17'd41240, 17'd35760, 17'd18050},
        '{17'd2126,  17'd7152,  17'd722},
        '{17'd1930,  17'd11920, 17'd95050}
    };

    // Division by a constant: q = floor(x * M / 2^K), then one correction.
    localparam logic [16:0] DIV_D [3] = '{17'd95047, 17'd10000, 17'd108883};
    localparam int          DIV_K [3] = '{47, 44, 47};
    localparam logic [31:0] DIV_M [3] = '{
        32'((64'd1 << 47) / 95047),
        32'((64'd1 << 44) / 10000),
        32'((64'd1 << 47) / 108883)
    };

    localparam int          LIN_DIV_K = 37;
    localparam logic [31:0] LIN_DIV_M = 32'((64'd1 << 37) / 1000);

    typedef logic [LW-1:0] t_q30;

    typedef struct packed {
        t_q30 red;
        t_q30 green;
        t_q30 blue;
    } t_lin_px;

    typedef t_q30 t_lin_tbl [256];

    // Linear light of one 8-bit sRGB code, evaluated at elaboration only.
    function automatic t_q30 lin_val(int unsigned c);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned r;
        longint unsigned cand;
        longint unsigned p;
        int i;
        if (c * 100000 > 1031475) begin
            t  = (64'(1000 * c + 14025) << QB) / 269025;
            t2 = (t * t) >> QB;
            r  = 0;
            for (i = 30; i >= 0; i--) begin
                cand = r | (64'd1 << i);
                if (cand <= (64'd1 << QB)) begin
                    p = (cand * cand) >> QB;
                    p = (p * cand) >> QB;
                    p = (p * cand) >> QB;
                    p = (p * cand) >> QB;
                    if (p <= t2) begin
                        r = cand;
                    end
                end
            end
            return LW'((t2 * r) >> QB);
        end
        return LW'(((64'(c) << QB) * 100) / 329460);
    endfunction

    function automatic t_lin_tbl build_lin();
        t_lin_tbl tbl;
        for (int c = 0; c < 256; c++) begin
            tbl[c] = lin_val(c);
        end
        return tbl;
    endfunction

    localparam t_lin_tbl LIN_TBL = build_lin();

endpackage
`default_nettype wire

// ----- rtl/s2l_front.sv -----
`default_nettype none
// ============================================================================
// s2l_front: gamma expansion of the incoming pixel
// Maps each 8-bit sRGB component to linear light in Q30 through a table.
// ============================================================================
module s2l_front
    import s2l_pkg::*;
(
    input  wire logic [7:0] i_red_in,
    input  wire logic [7:0] i_green_in,
    input  wire logic [7:0] i_blue_in,
    output t_lin_px         o_px
);

    assign o_px.red   = LIN_TBL[i_red_in];
    assign o_px.green = LIN_TBL[i_green_in];
    assign o_px.blue  = LIN_TBL[i_blue_in];

endmodule
`default_nettype wire

// ----- rtl/s2l_fifo.sv -----
`default_nettype none
// ============================================================================
// s2l_fifo: short queue between the front end and the arithmetic pipeline
// Small register FIFO so that input and pipeline stall independently.
// ============================================================================
module s2l_fifo
    import s2l_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_lin_px i_data,
    output logic         o_full,
    input  wire logic    i_pop,
    output t_lin_px      o_data,
    output logic         o_empty
);

    t_lin_px                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     r_wr, n_wr;
    logic [FIFO_AW-1:0]     r_rd, n_rd;
    logic [FIFO_AW:0]       r_cnt, n_cnt;
    logic                   s_wr_en;
    logic                   s_rd_en;

    assign o_full  = (r_cnt == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign s_wr_en = i_push && !o_full;
    assign s_rd_en = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = s_wr_en ? r_wr + 1'b1 : r_wr;
        n_rd  = s_rd_en ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (FIFO_AW + 1)'(s_wr_en) - (FIFO_AW + 1)'(s_rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/s2l_labf.sv -----
`default_nettype none
// ============================================================================
// s2l_labf: CIELAB companding function of one normalized channel
// Bit-serial cube root unrolled into a pipeline, two stages per result bit,
// with the linear segment carried alongside and selected at the end.
// ============================================================================
module s2l_labf
    import s2l_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [LW-1:0] i_t,
    input  wire logic [LW-1:0] i_lin,
    output logic      [LW-1:0] o_f
);

    // First half of each bit: candidate and its truncated square.
    logic [LW-1:0] r_ha_root [CB_BITS];
    logic [LW-1:0] r_ha_val  [CB_BITS];
    logic [LW-1:0] r_ha_lin  [CB_BITS];
    logic          r_ha_sel  [CB_BITS];
    logic [LW-1:0] r_ha_cand [CB_BITS];
    logic [31:0]   r_ha_sq   [CB_BITS];
    // Second half: cube compared against the operand.
    logic [LW-1:0] r_hb_root [CB_BITS];
    logic [LW-1:0] r_hb_val  [CB_BITS];
    logic [LW-1:0] r_hb_lin  [CB_BITS];
    logic          r_hb_sel  [CB_BITS];

    for (genvar j = 0; j < CB_BITS; j++) begin : g_bit
        localparam int BIT = CB_BITS - 1 - j;
        logic [LW-1:0]   s_root;
        logic [LW-1:0]   s_val;
        logic [LW-1:0]   s_lin;
        logic            s_sel;
        logic [LW-1:0]   s_cand;
        logic [2*LW-1:0] s_sq;
        logic [63:0]     s_cube;
        logic [33:0]     s_p;

        if (j == 0) begin : g_first
            assign s_root = '0;
            assign s_val  = i_t;
            assign s_lin  = i_lin;
            assign s_sel  = (i_t > LAB_TH);
        end else begin : g_next
            assign s_root = r_hb_root[j-1];
            assign s_val  = r_hb_val[j-1];
            assign s_lin  = r_hb_lin[j-1];
            assign s_sel  = r_hb_sel[j-1];
        end

        assign s_cand = s_root | (LW'(1) << BIT);
        assign s_sq   = s_cand * s_cand;
        assign s_cube = 64'(r_ha_sq[j]) * 64'(r_ha_cand[j]);
        assign s_p    = s_cube[63:QB];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ha_root[j] <= s_root;
                r_ha_val[j]  <= s_val;
                r_ha_lin[j]  <= s_lin;
                r_ha_sel[j]  <= s_sel;
                r_ha_cand[j] <= s_cand;
                r_ha_sq[j]   <= s_sq[QB+31:QB];
                r_hb_val[j]  <= r_ha_val[j];
                r_hb_lin[j]  <= r_ha_lin[j];
                r_hb_sel[j]  <= r_ha_sel[j];
                r_hb_root[j] <= (s_p <= 34'(r_ha_val[j])) ? r_ha_cand[j] : r_ha_root[j];
            end
        end
    end

    assign o_f = r_hb_sel[CB_BITS-1] ? r_hb_root[CB_BITS-1] : r_hb_lin[CB_BITS-1];

endmodule
`default_nettype wire

// ----- rtl/s2l_back.sv -----
`default_nettype none
// ============================================================================
// s2l_back: arithmetic pipeline from linear RGB to rounded L, a and b
// Matrix, white point division, companding, scaling and saturation. The
// whole pipeline advances together; the last stage is the output register.
// ============================================================================
module s2l_back
    import s2l_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_lin_px            i_px,
    input  wire logic               i_avail,
    output logic                    o_take,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output logic        [14:0]      o_lightness,
    output logic signed [15:0]      o_green_red,
    output logic signed [15:0]      o_blue_yellow
);

    localparam logic signed [OW-1:0] L_MAX_S = OW'(L_MAX);
    localparam logic signed [OW-1:0] C_MAX_S = OW'(32767);
    localparam logic signed [OW-1:0] C_MIN_S = -OW'(32768);

    logic [BACK_STAGES-1:0] r_vld, n_vld;
    logic                   s_en;
    logic [LW-1:0]          s_in [3];

    logic [XW-1:0]  r_s1_x   [3];
    logic [XW-1:0]  r_s2_x   [3];
    logic [55:0]    r_s2_pph [3];
    logic [55:0]    r_s2_ppl [3];
    logic [XW-1:0]  r_s3_x   [3];
    logic [31:0]    r_s3_q   [3];
    logic [LW-1:0]  r_s4_t   [3];
    logic [36:0]    r_l1_y   [3];
    logic [LW-1:0]  r_l1_t   [3];
    logic [36:0]    r_l2_y   [3];
    logic [63:0]    r_l2_pph [3];
    logic [63:0]    r_l2_ppl [3];
    logic [LW-1:0]  r_l2_t   [3];
    logic [36:0]    r_l3_y   [3];
    logic [31:0]    r_l3_q   [3];
    logic [LW-1:0]  r_l3_t   [3];
    logic [LW-1:0]  r_l4_t   [3];
    logic [LW-1:0]  r_l4_lin [3];
    logic [LW-1:0]  s_f      [3];

    logic signed [OW-1:0] r_lq, r_aq, r_bq;
    logic signed [OW-1:0] s_lr, s_ar, s_br;
    logic [14:0]          r_lightness;
    logic signed [15:0]   r_green_red, r_blue_yellow;

    // Round a signed Q30 value to FRAC_BITS, half away from zero.
    function automatic logic signed [OW-1:0] round_q(logic signed [OW-1:0] v);
        logic [OW-1:0] mag;
        logic [OW-1:0] m;
        mag = v[OW-1] ? OW'(-v) : OW'(v);
        m   = (mag + (OW'(1) << (SH - 1))) >> SH;
        return v[OW-1] ? -$signed(m) : $signed(m);
    endfunction

    // The pipeline moves unless a finished result waits at the output.
    assign s_en    = !r_vld[BACK_STAGES-1] || i_pop;
    assign o_take  = s_en && i_avail;
    assign o_empty = !r_vld[BACK_STAGES-1];
    assign n_vld   = {r_vld[BACK_STAGES-2:0], o_take};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (s_en) begin
            r_vld <= n_vld;
        end
    end

    assign s_in[0] = i_px.red;
    assign s_in[1] = i_px.green;
    assign s_in[2] = i_px.blue;

    for (genvar k = 0; k < 3; k++) begin : g_ch
        logic [79:0] s_s3_sum;
        logic [48:0] s_s4_rem;
        logic [71:0] s_l3_sum;
        logic [37:0] s_l4_rem;
        logic [31:0] s_l4_q;

        assign s_s3_sum = {r_s2_pph[k], 24'b0} + 80'(r_s2_ppl[k]);
        assign s_s4_rem = 49'(r_s3_x[k]) - 49'(r_s3_q[k]) * 49'(DIV_D[k]);
        assign s_l3_sum = 72'({r_l2_pph[k], 20'b0}) + 72'(r_l2_ppl[k]);
        assign s_l4_rem = 38'(r_l3_y[k]) - 38'(r_l3_q[k]) * 38'(1000);
        assign s_l4_q   = r_l3_q[k] + 32'(s_l4_rem >= 38'(1000));

        always_ff @(posedge i_clk) begin
            if (s_en) begin
                r_s1_x[k]   <= XW'(MAT[k][0]) * XW'(s_in[0])
                             + XW'(MAT[k][1]) * XW'(s_in[1])
                             + XW'(MAT[k][2]) * XW'(s_in[2]);
                r_s2_x[k]   <= r_s1_x[k];
                r_s2_pph[k] <= 56'(r_s1_x[k][XW-1:24]) * 56'(DIV_M[k]);
                r_s2_ppl[k] <= 56'(r_s1_x[k][23:0]) * 56'(DIV_M[k]);
                r_s3_x[k]   <= r_s2_x[k];
                r_s3_q[k]   <= 32'(s_s3_sum >> DIV_K[k]);
                r_s4_t[k]   <= LW'(r_s3_q[k] + 32'(s_s4_rem >= 49'(DIV_D[k])));
                // Linear segment of the companding curve.
                r_l1_y[k]   <= 37'(7787) * 37'(r_s4_t[k][23:0]);
                r_l1_t[k]   <= r_s4_t[k];
                r_l2_y[k]   <= r_l1_y[k];
                r_l2_pph[k] <= 64'(r_l1_y[k][36:20]) * 64'(LIN_DIV_M);
                r_l2_ppl[k] <= 64'(r_l1_y[k][19:0]) * 64'(LIN_DIV_M);
                r_l2_t[k]   <= r_l1_t[k];
                r_l3_y[k]   <= r_l2_y[k];
                r_l3_q[k]   <= 32'(s_l3_sum >> LIN_DIV_K);
                r_l3_t[k]   <= r_l2_t[k];
                r_l4_t[k]   <= r_l3_t[k];
                r_l4_lin[k] <= LW'(s_l4_q) + LAB_OFFSET;
            end
        end

        s2l_labf u_labf (
            .i_clk (i_clk),
            .i_en  (s_en),
            .i_t   (r_l4_t[k]),
            .i_lin (r_l4_lin[k]),
            .o_f   (s_f[k])
        );
    end

    assign s_lr = round_q(r_lq);
    assign s_ar = round_q(r_aq);
    assign s_br = round_q(r_bq);

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_lq <= $signed(OW'(s_f[1]) * OW'(116) - OW'(64'd16 << QB));
            r_aq <= $signed(OW'(500) * (OW'(s_f[0]) - OW'(s_f[1])));
            r_bq <= $signed(OW'(200) * (OW'(s_f[1]) - OW'(s_f[2])));

            if (s_lr < 0) begin
                r_lightness <= '0;
            end else if (s_lr > L_MAX_S) begin
                r_lightness <= 15'(L_MAX);
            end else begin
                r_lightness <= s_lr[14:0];
            end

            if (s_ar > C_MAX_S) begin
                r_green_red <= 16'sh7fff;
            end else if (s_ar < C_MIN_S) begin
                r_green_red <= 16'sh8000;
            end else begin
                r_green_red <= s_ar[15:0];
            end

            if (s_br > C_MAX_S) begin
                r_blue_yellow <= 16'sh7fff;
            end else if (s_br < C_MIN_S) begin
                r_blue_yellow <= 16'sh8000;
            end else begin
                r_blue_yellow <= s_br[15:0];
            end
        end
    end

    assign o_lightness   = r_lightness;
    assign o_green_red   = r_green_red;
    assign o_blue_yellow = r_blue_yellow;

endmodule
`default_nettype wire

// ----- rtl/srgb_to_cielab.sv -----
`default_nettype none
// ============================================================================
// srgb_to_cielab: 8-bit sRGB pixel to CIELAB (D65) in fixed point, a and b signed
// Gamma table, queue, and a fully pipelined XYZ, cube root and scaling path.
// ============================================================================
// The converter takes one pixel per clock while full is low and delivers one
// L, a, b triple per pixel, in input order, with 8 fractional bits. A pixel
// pushed passes through the input queue and 72 pipeline stages, most of them
// the 31-bit cube root, which resolves one result bit every two stages, to
// reach the result ports. When pop is held low the pipeline holds once a
// result waits at the output; the four-entry queue then fills and full rises.
module srgb_to_cielab
    import s2l_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [7:0]         i_red_in,
    input  wire logic [7:0]         i_green_in,
    input  wire logic [7:0]         i_blue_in,
    output logic                    empty,
    input  wire logic               pop,
    output logic        [14:0]      o_lightness,
    output logic signed [15:0]      o_green_red,
    output logic signed [15:0]      o_blue_yellow
);

    t_lin_px s_front_px;
    t_lin_px s_queue_px;
    logic    s_queue_empty;
    logic    s_take;

    s2l_front u_front (
        .i_red_in   (i_red_in),
        .i_green_in (i_green_in),
        .i_blue_in  (i_blue_in),
        .o_px       (s_front_px)
    );

    s2l_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (s_front_px),
        .o_full  (full),
        .i_pop   (s_take),
        .o_data  (s_queue_px),
        .o_empty (s_queue_empty)
    );

    s2l_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_px          (s_queue_px),
        .i_avail       (!s_queue_empty),
        .o_take        (s_take),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_lightness   (o_lightness),
        .o_green_red   (o_green_red),
        .o_blue_yellow (o_blue_yellow)
    );

endmodule
`default_nettype wire
